// ----- rtl/hdmi_vsdb_stereo_scan_macros.svh -----
// Assertion macros used by the stereo scan parser (hvss_parse).
// Each macro expects clk and rst_n in scope; no other dependencies.
`ifndef HDMI_VSDB_STEREO_SCAN_MACROS_SVH
`define HDMI_VSDB_STEREO_SCAN_MACROS_SVH

// same-cycle implication
`define HVSS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HVSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/hvss_pkg.sv -----
// Package for the HDMI vendor block stereo scan: beat type, offsets and byte codes.
// No dependencies; imported by hvss_parse and hdmi_vsdb_stereo_scan.
package hvss_pkg;

    localparam int BLOCK_BYTES = 128;
    localparam int OFFSET_W    = $clog2(BLOCK_BYTES);
    localparam int HDR_W       = OFFSET_W + 2;

    localparam logic [OFFSET_W-1:0] LAST_OFFSET      = OFFSET_W'(BLOCK_BYTES - 1);
    localparam logic [OFFSET_W-1:0] COLL_END_OFFSET  = OFFSET_W'(2);
    localparam logic [OFFSET_W-1:0] COLL_START       = OFFSET_W'(4);
    localparam logic [HDR_W-1:0]    FIRST_HDR_OFFSET = HDR_W'(4);

    localparam logic [1:0] TAG_VENDOR   = 2'b11;
    localparam logic [4:0] MIN_VSDB_LEN = 5'd8;

    localparam logic [7:0] OUI_BYTE0 = 8'h03;
    localparam logic [7:0] OUI_BYTE1 = 8'h0c;
    localparam logic [7:0] OUI_BYTE2 = 8'h00;

    localparam logic [4:0] REL_OUI0  = 5'd1;
    localparam logic [4:0] REL_OUI1  = 5'd2;
    localparam logic [4:0] REL_OUI2  = 5'd3;
    localparam logic [4:0] REL_FLAGS = 5'd8;
    localparam logic [4:0] REL_AFTER_FLAGS = 5'd9;
    localparam logic [4:0] LATENCY_SKIP    = 5'd2;

    localparam int FLAG_LATENCY_BIT    = 7;
    localparam int FLAG_I_LATENCY_BIT  = 6;
    localparam int FLAG_HDMI_VIDEO_BIT = 5;
    localparam int STEREO_PRESENT_BIT  = 7;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       clear;
    } beat_t;

endpackage

// ----- rtl/hvss_parse.sv -----
// Parse state and next-state logic for the data block walk and stereo flag.
// Depends on hvss_pkg and hdmi_vsdb_stereo_scan_macros.svh.
`include "hdmi_vsdb_stereo_scan_macros.svh"

module hvss_parse (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  hvss_pkg::beat_t beat,
    output logic           flag_next
);
    import hvss_pkg::*;

    logic [OFFSET_W-1:0] byte_offset_reg, byte_offset_next;
    logic [7:0]          collection_end_reg, collection_end_next;
    logic [HDR_W-1:0]    next_header_reg, next_header_next;
    logic [4:0]          block_length_reg, block_length_next;
    logic                candidate_reg, candidate_next;
    logic                oui_matched_reg, oui_matched_next;
    logic [4:0]          stereo_offset_reg, stereo_offset_next;
    logic                flag_reg;

    logic [HDR_W-1:0]    offset_wide;
    logic [7:0]          coll_end_cur;
    logic [4:0]          len_new;
    logic [4:0]          rel;
    logic [4:0]          stereo_pos;

    always_comb
    begin
        offset_wide  = HDR_W'(byte_offset_reg);
        coll_end_cur = (byte_offset_reg == COLL_END_OFFSET) ? beat.data : collection_end_reg;
        len_new      = beat.data[4:0];
        rel          = byte_offset_reg[4:0] - next_header_reg[4:0] + block_length_reg + 5'd1;
        stereo_pos   = REL_AFTER_FLAGS
                     + (beat.data[FLAG_LATENCY_BIT]   ? LATENCY_SKIP : 5'd0)
                     + (beat.data[FLAG_I_LATENCY_BIT] ? LATENCY_SKIP : 5'd0);

        collection_end_next = coll_end_cur;
        next_header_next    = next_header_reg;
        block_length_next   = block_length_reg;
        candidate_next      = candidate_reg;
        oui_matched_next    = oui_matched_reg;
        stereo_offset_next  = stereo_offset_reg;
        flag_next           = flag_reg & ~beat.clear;

        if (offset_wide == next_header_reg)
        begin
            if (byte_offset_reg >= COLL_START && {1'b0, byte_offset_reg} < coll_end_cur)
            begin
                block_length_next  = len_new;
                candidate_next     = (beat.data[6:5] == TAG_VENDOR) && (len_new >= MIN_VSDB_LEN);
                oui_matched_next   = 1'b0;
                stereo_offset_next = 5'd0;
                next_header_next   = offset_wide + HDR_W'(len_new) + HDR_W'(1);
            end
            else
            begin
                candidate_next = 1'b0;
            end
        end
        else if (candidate_reg && offset_wide < next_header_reg)
        begin
            case (rel)
                REL_OUI0:  oui_matched_next = (beat.data == OUI_BYTE0);
                REL_OUI1:  if (beat.data != OUI_BYTE1) oui_matched_next = 1'b0;
                REL_OUI2:  if (beat.data != OUI_BYTE2) oui_matched_next = 1'b0;
                REL_FLAGS:
                begin
                    if (oui_matched_reg && beat.data[FLAG_HDMI_VIDEO_BIT])
                        stereo_offset_next = (stereo_pos <= block_length_reg) ? stereo_pos : 5'd0;
                end
                default:
                begin
                    if (stereo_offset_reg != 5'd0 && rel == stereo_offset_reg
                        && beat.data[STEREO_PRESENT_BIT])
                        flag_next = 1'b1;
                end
            endcase
        end

        if (beat.last || byte_offset_reg >= LAST_OFFSET)
        begin
            byte_offset_next    = '0;
            collection_end_next = 8'd0;
            next_header_next    = FIRST_HDR_OFFSET;
            block_length_next   = 5'd0;
            candidate_next      = 1'b0;
            oui_matched_next    = 1'b0;
            stereo_offset_next  = 5'd0;
        end
        else
        begin
            byte_offset_next = byte_offset_reg + OFFSET_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_offset_reg    <= '0;
            collection_end_reg <= 8'd0;
            next_header_reg    <= FIRST_HDR_OFFSET;
            block_length_reg   <= 5'd0;
            candidate_reg      <= 1'b0;
            oui_matched_reg    <= 1'b0;
            stereo_offset_reg  <= 5'd0;
            flag_reg           <= 1'b0;
        end
        else if (advance)
        begin
            byte_offset_reg    <= byte_offset_next;
            collection_end_reg <= collection_end_next;
            next_header_reg    <= next_header_next;
            block_length_reg   <= block_length_next;
            candidate_reg      <= candidate_next;
            oui_matched_reg    <= oui_matched_next;
            stereo_offset_reg  <= stereo_offset_next;
            flag_reg           <= flag_next;
        end
    end

    `HVSS_ASSERT_NEXT(a_last_restarts, advance && beat.last, byte_offset_reg == '0, "last beat did not restart offset")
    `HVSS_ASSERT_NEXT(a_flag_sticky, advance && !beat.clear && flag_reg, flag_reg, "stereo flag dropped without clear")
    `HVSS_ASSERT_NOW(a_header_floor, 1'b1, next_header_reg >= FIRST_HDR_OFFSET, "header offset below collection start")

endmodule

// ----- rtl/hdmi_vsdb_stereo_scan.sv -----
// Top level of the HDMI vendor block stereo scan: beat register, parser, result register.
// Depends on hvss_pkg and hvss_parse.
//
//  channel   signals                                   direction
//  data      data_valid data_stall data_byte
//            last_byte clear_flag                      into block
//  result    result_valid result_stall
//            stereo_supported                          out of block
//
// One result beat per data beat; a beat passes the beat register, then the result register.
// Throughput is one beat per cycle while the result is not stalled, set by the single parse stage between the
// beat register and the result register.
// Reset clears the parse position, the stereo flag and both valid flags.
// A stalled result holds the parse stage; one further data beat waits in the beat register.

module hdmi_vsdb_stereo_scan (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       data_valid,
    output logic       data_stall,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic       clear_flag,
    output logic       result_valid,
    input  logic       result_stall,
    output logic       stereo_supported
);
    import hvss_pkg::*;

    logic  hold_valid_reg, hold_valid_next;
    beat_t beat_reg;
    logic  res_valid_reg, res_valid_next;
    logic  res_flag_reg;
    logic  advance;
    logic  accept;
    logic  flag_next;

    assign advance    = hold_valid_reg && (!res_valid_reg || !result_stall);
    assign data_stall = hold_valid_reg && !advance;
    assign accept     = data_valid && !data_stall;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept)
            hold_valid_next = 1'b1;
        else if (advance)
            hold_valid_next = 1'b0;

        res_valid_next = res_valid_reg && result_stall;
        if (advance)
            res_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            beat_reg <= '{data: data_byte, last: last_byte, clear: clear_flag};
        if (advance)
            res_flag_reg <= flag_next;
    end

    hvss_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .beat      (beat_reg),
        .flag_next (flag_next)
    );

    assign result_valid     = res_valid_reg;
    assign stereo_supported = res_flag_reg;

endmodule

// ----- tb/sv/tb.sv -----
// Testbench for hdmi_vsdb_stereo_scan: streams CEA extension block bytes and checks the
// sticky stereo flag on every result beat against an in-bench scan of the same bytes.
// Depends on hvss_pkg and the stereo scan RTL; self-contained otherwise.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hvss_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int RX_HOLD_AT     = 500;
    localparam int TARGET_BEATS   = 1650;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       data_valid = 1'b0;
    logic       data_stall;
    logic [7:0] data_byte = 8'h00;
    logic       last_byte = 1'b0;
    logic       clear_flag = 1'b0;
    logic       result_valid;
    logic       result_stall = 1'b0;
    logic       stereo_supported;

    beat_t edid_bytes_q[$];
    logic  stereo_flag_q[$];

    int idle_pct = 0;
    int stall_pct = 0;
    logic tx_pause = 1'b0;
    int bytes_sent = 0;
    int total_bytes = 0;
    int flags_checked = 0;
    int mismatches = 0;
    int quiet_cycles = 0;
    int rx_hold_left = 0;
    logic rx_held = 1'b0;

    // scan state
    logic [6:0] ofs;
    logic [7:0] coll_end;
    logic [8:0] next_hdr;
    logic [4:0] blk_len;
    logic       vsdb_cand;
    logic       oui_ok;
    logic [4:0] stereo_rel;
    logic       stereo_flag;

    hdmi_vsdb_stereo_scan u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .data_valid       (data_valid),
        .data_stall       (data_stall),
        .data_byte        (data_byte),
        .last_byte        (last_byte),
        .clear_flag       (clear_flag),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .stereo_supported (stereo_supported)
    );

    always #2 clk = ~clk;

    function automatic void restart_scan();
        ofs        = '0;
        coll_end   = '0;
        next_hdr   = FIRST_HDR_OFFSET;
        blk_len    = '0;
        vsdb_cand  = 1'b0;
        oui_ok     = 1'b0;
        stereo_rel = '0;
    endfunction

    function automatic logic scan_byte(input logic [7:0] b, input logic last, input logic clr);
        logic [8:0] base;
        logic [4:0] rel;
        logic [4:0] j;
        if (clr)
            stereo_flag = 1'b0;
        if (ofs == COLL_END_OFFSET)
            coll_end = b;
        if (9'(ofs) == next_hdr)
        begin
            if (ofs >= COLL_START && 8'(ofs) < coll_end)
            begin
                blk_len    = b[4:0];
                vsdb_cand  = (b[6:5] == TAG_VENDOR) && (blk_len >= MIN_VSDB_LEN);
                oui_ok     = 1'b0;
                stereo_rel = '0;
                next_hdr   = 9'(ofs) + 9'(blk_len) + 9'd1;
            end
            else
            begin
                vsdb_cand = 1'b0;
            end
        end
        else if (vsdb_cand && 9'(ofs) < next_hdr)
        begin
            base = next_hdr - 9'(blk_len) - 9'd1;
            rel  = 5'(9'(ofs) - base);
            if (rel == REL_OUI0)
                oui_ok = (b == OUI_BYTE0);
            else if (rel == REL_OUI1)
            begin
                if (b != OUI_BYTE1)
                    oui_ok = 1'b0;
            end
            else if (rel == REL_OUI2)
            begin
                if (b != OUI_BYTE2)
                    oui_ok = 1'b0;
            end
            else if (rel == REL_FLAGS)
            begin
                if (oui_ok && b[FLAG_HDMI_VIDEO_BIT])
                begin
                    j = REL_AFTER_FLAGS;
                    if (b[FLAG_LATENCY_BIT])
                        j = j + LATENCY_SKIP;
                    if (b[FLAG_I_LATENCY_BIT])
                        j = j + LATENCY_SKIP;
                    stereo_rel = (j <= blk_len) ? j : 5'd0;
                end
            end
            else if (stereo_rel != 0 && rel == stereo_rel)
            begin
                if (b[STEREO_PRESENT_BIT])
                    stereo_flag = 1'b1;
            end
        end
        if (last || ofs >= LAST_OFFSET)
            restart_scan();
        else
            ofs = ofs + 7'd1;
        return stereo_flag;
    endfunction

    function automatic void add_beat(input logic [7:0] d, input logic l, input logic c);
        beat_t bt;
        bt.data  = d;
        bt.last  = l;
        bt.clear = c;
        edid_bytes_q.push_back(bt);
    endfunction

    // One extension block with a random data block collection; mostly vendor blocks.
    task automatic add_ext_block();
        logic [7:0] blk [128];
        int         pos;
        int         len;
        int         j;
        int         stop_at;
        int         ending;
        logic       vendor;
        logic [7:0] flags;
        for (int i = 0; i < 128; i++)
            blk[i] = 8'($urandom);
        case ($urandom_range(9))
            0: blk[2] = 8'($urandom_range(0, 4));
            1: blk[2] = 8'($urandom_range(128, 255));
            default: blk[2] = 8'($urandom_range(12, 127));
        endcase
        pos = 4;
        while (pos < 128)
        begin
            vendor = ($urandom_range(3) != 0);
            len = vendor ? $urandom_range(6, 31) : $urandom_range(0, 31);
            blk[pos] = {1'($urandom_range(1)),
                        vendor ? TAG_VENDOR : 2'($urandom_range(2)), 5'(len)};
            if (vendor)
            begin
                if (pos + 1 < 128)
                    blk[pos + 1] = ($urandom_range(7) == 0) ? 8'($urandom) : OUI_BYTE0;
                if (pos + 2 < 128)
                    blk[pos + 2] = ($urandom_range(7) == 0) ? 8'($urandom) : OUI_BYTE1;
                if (pos + 3 < 128)
                    blk[pos + 3] = ($urandom_range(7) == 0) ? 8'($urandom) : OUI_BYTE2;
                flags = 8'($urandom);
                if ($urandom_range(4) != 0)
                    flags[FLAG_HDMI_VIDEO_BIT] = 1'b1;
                if (pos + 8 < 128)
                    blk[pos + 8] = flags;
                j = 9 + (flags[FLAG_LATENCY_BIT] ? 2 : 0) + (flags[FLAG_I_LATENCY_BIT] ? 2 : 0);
                if (pos + j < 128)
                    blk[pos + j][STEREO_PRESENT_BIT] = ($urandom_range(2) == 0);
            end
            pos = pos + len + 1;
        end
        ending = $urandom_range(19);
        stop_at = (ending < 3) ? $urandom_range(0, 127) : 127;
        for (int i = 0; i <= stop_at; i++)
            add_beat(blk[i],
                     (i == stop_at) && (ending != 19),
                     (i == 0) ? ($urandom_range(3) != 0) : ($urandom_range(63) == 0));
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        beat_t nxt;
        if (!rst_n)
        begin
            data_valid <= 1'b0;
            data_byte  <= 8'h00;
            last_byte  <= 1'b0;
            clear_flag <= 1'b0;
        end
        else
        begin
            if (data_valid && !data_stall)
            begin
                stereo_flag_q.push_back(scan_byte(data_byte, last_byte, clear_flag));
                bytes_sent <= bytes_sent + 1;
            end
            if (!data_valid || !data_stall)
            begin
                if (edid_bytes_q.size() != 0 && !tx_pause && $urandom_range(99) >= idle_pct)
                begin
                    nxt = edid_bytes_q.pop_front();
                    data_valid <= 1'b1;
                    data_byte  <= nxt.data;
                    last_byte  <= nxt.last;
                    clear_flag <= nxt.clear;
                end
                else
                begin
                    data_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        logic want;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (stereo_flag_q.size() == 0)
                begin
                    $display("%0t: unexpected beat, stereo_supported %b", $time,
                             stereo_supported);
                    mismatches++;
                end
                else
                begin
                    want = stereo_flag_q.pop_front();
                    if (want !== stereo_supported)
                    begin
                        $display("%0t: stereo_supported wrong, exp %b got %b", $time,
                                 want, stereo_supported);
                        mismatches++;
                    end
                end
                flags_checked++;
            end
            if (rx_hold_left != 0)
            begin
                rx_hold_left--;
                result_stall <= 1'b1;
            end
            else if (!rx_held && flags_checked >= RX_HOLD_AT)
            begin
                rx_held = 1'b1;
                rx_hold_left = RX_HOLD_CYCLES;
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((data_valid && !data_stall) || (result_valid && !result_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        stereo_flag = 1'b0;
        restart_scan();

        // minimal block: vendor block at offset 4, OUI match, stereo bit set
        add_beat(8'h00, 1'b0, 1'b1);
        add_beat(8'hff, 1'b0, 1'b0);
        add_beat(8'd20, 1'b0, 1'b0);
        add_beat(8'hff, 1'b0, 1'b0);
        add_beat({1'b0, TAG_VENDOR, 5'd9}, 1'b0, 1'b0);
        add_beat(OUI_BYTE0, 1'b0, 1'b0);
        add_beat(OUI_BYTE1, 1'b0, 1'b0);
        add_beat(OUI_BYTE2, 1'b0, 1'b0);
        repeat (4)
            add_beat(8'h55, 1'b0, 1'b0);
        add_beat(8'h20, 1'b0, 1'b0);
        add_beat(8'h80, 1'b1, 1'b0);
        // early last with clear, then last at offset zero without clear
        add_beat(8'hff, 1'b1, 1'b1);
        add_beat(8'h00, 1'b1, 1'b0);
        // tag bit 7 set on a vendor header, flag kept over a short block
        add_beat(8'h00, 1'b0, 1'b0);
        add_beat(8'h00, 1'b0, 1'b0);
        add_beat(8'hff, 1'b0, 1'b0);
        add_beat(8'h00, 1'b0, 1'b0);
        add_beat(8'hff, 1'b1, 1'b0);

        while (edid_bytes_q.size() < TARGET_BEATS - 20)
            add_ext_block();
        total_bytes = edid_bytes_q.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin idle_pct <= 0;  stall_pct <= 0;  end
                1: begin idle_pct <= 57; stall_pct <= 0;  end
                2: begin idle_pct <= 0;  stall_pct <= 57; end
                default: begin idle_pct <= 30; stall_pct <= 30; end
            endcase
            if (ph == 2)
            begin
                tx_pause <= 1'b1;
                @(posedge clk);
                while (data_valid || stereo_flag_q.size() != 0)
                    @(posedge clk);
                tx_pause <= 1'b0;
            end
            while (bytes_sent < ((ph + 1) * total_bytes) / 4)
                @(posedge clk);
        end

        while (stereo_flag_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
